// ===== rtl/emd_pkg.sv =====
// ----------------------------------------------------------------------------
// emd_pkg
// Transaction types and fixed codes for the escape method D frequency model.
// ----------------------------------------------------------------------------
package emd_pkg;

   localparam int RANGE_W   = 25;
   localparam int SYMBOL_W  = 8;
   localparam int SYMOUT_W  = 9;

   localparam logic OP_ENCODE = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   typedef struct packed {
      logic                operation;
      logic [SYMBOL_W-1:0] symbol_in;
      logic [RANGE_W-1:0]  target_count;
   } req_type;

   typedef struct packed {
      logic [RANGE_W-1:0]  range_low;
      logic [RANGE_W-1:0]  range_high;
      logic [RANGE_W-1:0]  range_total;
      logic [SYMOUT_W-1:0] symbol_out;
      logic                is_escape;
      logic [RANGE_W-1:0]  next_total;
      logic                saturated;
      logic                last;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_UPDATE = 5'b01000,
      ST_SECOND = 5'b10000
   } state_type;

endpackage

// ===== rtl/emd_count_ram.sv =====
// ----------------------------------------------------------------------------
// emd_count_ram
// Symbol count memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module emd_count_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 24
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/escape_method_d_adaptive_model_top.sv =====
// ----------------------------------------------------------------------------
// escape_method_d_adaptive_model_top
// Adaptive order-0 model with escape method D for an arithmetic coder.
// ----------------------------------------------------------------------------
// After reset the block clears its count memory, one entry a cycle, with busy
// high. A transaction is taken when start is high and busy is low. Decodes
// that resolve to an escape (empty model, target in the escape band, or
// alphabet exhausted after an escape) answer on the cycle after acceptance
// and leave busy low. Every other transaction walks the count memory through
// its single read port, one entry a cycle, then writes the updated count
// back unless the total is saturated. Busy stays high until its last result
// is issued (for an encode of an unseen symbol, an escape result and then
// the uniform interval on consecutive cycles), so no new transaction is
// taken before it is done. Each result is shown for one cycle on rsp_valid;
// the receiver cannot stall it. Encodes of symbols outside the alphabet
// produce no result.
// ----------------------------------------------------------------------------
module escape_method_d_adaptive_model_top #(
   parameter int NUM_SYMBOLS = 256,
   parameter int COUNT_BITS  = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  emd_pkg::req_type req_payload,
   output logic             busy,
   output logic             rsp_valid,
   output emd_pkg::rsp_type rsp_payload
);

   import emd_pkg::*;

   localparam int SW   = $clog2(NUM_SYMBOLS);
   localparam int DW   = $clog2(NUM_SYMBOLS + 1);
   localparam int CW   = COUNT_BITS;
   localparam int AW   = CW + 2;
   localparam int CMPW = (AW > RANGE_W) ? AW : RANGE_W;
   localparam int IW   = ((SW > SYMBOL_W) ? SW : SYMBOL_W) + 1;

   localparam logic [SW-1:0]       LAST_ADDR = SW'(NUM_SYMBOLS - 1);
   localparam logic [DW-1:0]       N_D       = DW'(NUM_SYMBOLS);
   localparam logic [SYMOUT_W-1:0] ESC_SYM   = SYMOUT_W'(NUM_SYMBOLS);
   localparam logic [CW-1:0]       LIMIT     = {CW{1'b1}};

   state_type           state_ff, state_in;
   logic [SW-1:0]       addr_ff, addr_in;
   logic                issue_ff, issue_in;
   logic                proc_valid_ff, proc_valid_in;
   logic [SW-1:0]       proc_idx_ff, proc_idx_in;
   logic                op_ff, op_in;
   logic                aesc_mode_ff, aesc_mode_in;
   logic [SYMBOL_W-1:0] sym_ff, sym_in;
   logic [RANGE_W-1:0]  tgt_ff, tgt_in;
   logic [DW-1:0]       tgtc_ff, tgtc_in;
   logic [DW-1:0]       unseen_ff, unseen_in;
   logic [AW-1:0]       base_ff, base_in;
   logic [AW-1:0]       hi_ff, hi_in;
   logic [DW-1:0]       u_ff, u_in;
   logic [DW-1:0]       run_ff, run_in;
   logic [SW-1:0]       found_ff, found_in;
   logic                found_hit_ff, found_hit_in;
   logic [CW-1:0]       cfound_ff, cfound_in;
   logic                sat_ff, sat_in;
   logic [CW-1:0]       total_ff, total_in;
   logic [DW-1:0]       distinct_ff, distinct_in;
   logic                after_escape_ff, after_escape_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                ram_wr_en;
   logic [SW-1:0]       ram_wr_addr;
   logic [CW-1:0]       ram_wr_data;
   logic                ram_rd_en;
   logic [CW-1:0]       ram_rd_data;

   function automatic rsp_type make_rsp(
      input logic [RANGE_W-1:0]  lo,
      input logic [RANGE_W-1:0]  hi,
      input logic [RANGE_W-1:0]  tot,
      input logic [SYMOUT_W-1:0] sym,
      input logic                esc,
      input logic [RANGE_W-1:0]  nxt,
      input logic                sat,
      input logic                lst
   );
      rsp_type r;
      r.range_low   = lo;
      r.range_high  = hi;
      r.range_total = tot;
      r.symbol_out  = sym;
      r.is_escape   = esc;
      r.next_total  = nxt;
      r.saturated   = sat;
      r.last        = lst;
      return r;
   endfunction

   emd_count_ram #(
      .DEPTH (NUM_SYMBOLS),
      .WIDTH (CW)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (addr_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      logic [AW-1:0]      t2;
      logic [AW-1:0]      t2_new;
      logic [CW-1:0]      total_new;
      logic [DW-1:0]      unseen_now;
      logic [CMPW-1:0]    t2_minus_d;
      logic [CMPW-1:0]    tgt_w;
      logic               sat_now;
      logic               go_scan;
      logic               nz;
      logic [AW-1:0]      h;
      logic [RANGE_W-1:0] lo_u;

      t2         = {1'b0, total_ff, 1'b0};
      sat_now    = (total_ff == LIMIT);
      total_new  = sat_now ? total_ff : total_ff + 1'b1;
      t2_new     = {1'b0, total_new, 1'b0};
      unseen_now = N_D - distinct_ff;
      t2_minus_d = CMPW'(t2) - CMPW'(distinct_ff);
      tgt_w      = CMPW'(req_payload.target_count);
      go_scan    = 1'b0;
      nz         = (ram_rd_data != '0);
      h          = base_ff + {1'b0, ram_rd_data, 1'b0} - AW'(1);
      lo_u       = RANGE_W'(sym_ff) - RANGE_W'(u_ff);

      state_in        = state_ff;
      addr_in         = addr_ff;
      issue_in        = issue_ff;
      proc_valid_in   = 1'b0;
      proc_idx_in     = proc_idx_ff;
      op_in           = op_ff;
      aesc_mode_in    = aesc_mode_ff;
      sym_in          = sym_ff;
      tgt_in          = tgt_ff;
      tgtc_in         = tgtc_ff;
      unseen_in       = unseen_ff;
      base_in         = base_ff;
      hi_in           = hi_ff;
      u_in            = u_ff;
      run_in          = run_ff;
      found_in        = found_ff;
      found_hit_in    = found_hit_ff;
      cfound_in       = cfound_ff;
      sat_in          = sat_ff;
      total_in        = total_ff;
      distinct_in     = distinct_ff;
      after_escape_in = after_escape_ff;
      rsp_valid_in    = 1'b0;
      rsp_in          = rsp_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = addr_ff;
      ram_wr_data     = '0;
      ram_rd_en       = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
            if (addr_ff == LAST_ADDR) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (start) begin
               op_in        = req_payload.operation;
               sym_in       = req_payload.symbol_in;
               tgt_in       = req_payload.target_count;
               unseen_in    = unseen_now;
               aesc_mode_in = (req_payload.operation == OP_DECODE) && after_escape_ff;
               tgtc_in      = (tgt_w > CMPW'(unseen_now - 1'b1)) ?
                              unseen_now - 1'b1 : DW'(req_payload.target_count);
               if (req_payload.operation == OP_ENCODE) begin
                  go_scan = (IW'(req_payload.symbol_in) < IW'(NUM_SYMBOLS));
               end else if (after_escape_ff) begin
                  after_escape_in = 1'b0;
                  if (unseen_now == '0) begin
                     rsp_valid_in = 1'b1;
                     rsp_in = make_rsp('0, RANGE_W'(1), RANGE_W'(1), ESC_SYM, 1'b1,
                                       RANGE_W'(t2), 1'b0, 1'b1);
                  end else begin
                     go_scan = 1'b1;
                  end
               end else if (t2 == '0) begin
                  after_escape_in = 1'b1;
                  rsp_valid_in    = 1'b1;
                  rsp_in = make_rsp('0, RANGE_W'(1), RANGE_W'(1), ESC_SYM, 1'b1,
                                    RANGE_W'(unseen_now), 1'b0, 1'b1);
               end else if (tgt_w >= t2_minus_d) begin
                  after_escape_in = 1'b1;
                  rsp_valid_in    = 1'b1;
                  rsp_in = make_rsp(RANGE_W'(t2_minus_d), RANGE_W'(t2), RANGE_W'(t2),
                                    ESC_SYM, 1'b1, RANGE_W'(unseen_now), 1'b0, 1'b1);
               end else begin
                  go_scan = 1'b1;
               end
               if (go_scan) begin
                  state_in     = ST_SCAN;
                  addr_in      = '0;
                  issue_in     = 1'b1;
                  base_in      = '0;
                  hi_in        = '0;
                  u_in         = '0;
                  run_in       = '0;
                  found_in     = '0;
                  found_hit_in = 1'b0;
                  cfound_in    = '0;
               end
            end
         end

         ST_SCAN: begin
            ram_rd_en     = issue_ff;
            proc_valid_in = issue_ff;
            proc_idx_in   = addr_ff;
            if (issue_ff) begin
               if (addr_ff == LAST_ADDR) begin
                  issue_in = 1'b0;
               end else begin
                  addr_in = addr_ff + 1'b1;
               end
            end
            if (proc_valid_ff) begin
               if (op_ff == OP_ENCODE) begin
                  // accumulate only the entries below the coded symbol
                  if ((IW'(proc_idx_ff) < IW'(sym_ff)) && nz) begin
                     base_in = h;
                     u_in    = u_ff + 1'b1;
                  end
                  if (IW'(proc_idx_ff) == IW'(sym_ff)) begin
                     cfound_in = ram_rd_data;
                     hi_in     = h;
                  end
               end else if (aesc_mode_ff) begin
                  // count unseen entries until the clamped target is reached
                  if (!nz && !found_hit_ff) begin
                     if (run_ff == tgtc_ff) begin
                        found_in     = proc_idx_ff;
                        found_hit_in = 1'b1;
                     end else begin
                        run_in = run_ff + 1'b1;
                     end
                  end
               end else begin
                  // freeze the lower bound at the first interval above target
                  if (nz && !found_hit_ff) begin
                     if (CMPW'(h) > CMPW'(tgt_ff)) begin
                        found_in     = proc_idx_ff;
                        found_hit_in = 1'b1;
                        hi_in        = h;
                        cfound_in    = ram_rd_data;
                     end else begin
                        base_in = h;
                     end
                  end
               end
               if (proc_idx_ff == LAST_ADDR) begin
                  state_in = ST_UPDATE;
               end
            end
         end

         ST_UPDATE: begin
            sat_in       = sat_now;
            ram_wr_en    = !sat_now;
            ram_wr_addr  = (op_ff == OP_ENCODE) ? SW'(sym_ff) : found_ff;
            ram_wr_data  = cfound_ff + 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            if (!sat_now) begin
               total_in = total_ff + 1'b1;
               if (cfound_ff == '0) begin
                  distinct_in = distinct_ff + 1'b1;
               end
            end
            if (op_ff == OP_ENCODE) begin
               if (cfound_ff != '0) begin
                  rsp_in = make_rsp(RANGE_W'(base_ff), RANGE_W'(hi_ff), RANGE_W'(t2),
                                    SYMOUT_W'(sym_ff), 1'b0, RANGE_W'(t2_new),
                                    sat_now, 1'b1);
               end else begin
                  state_in = ST_SECOND;
                  if (t2 == '0) begin
                     rsp_in = make_rsp('0, RANGE_W'(1), RANGE_W'(1), ESC_SYM, 1'b1,
                                       RANGE_W'(unseen_ff), sat_now, 1'b0);
                  end else begin
                     rsp_in = make_rsp(RANGE_W'(t2_minus_d), RANGE_W'(t2), RANGE_W'(t2),
                                       ESC_SYM, 1'b1, RANGE_W'(unseen_ff), sat_now, 1'b0);
                  end
               end
            end else if (aesc_mode_ff) begin
               rsp_in = make_rsp(RANGE_W'(tgtc_ff), RANGE_W'(tgtc_ff) + 1'b1,
                                 RANGE_W'(unseen_ff), SYMOUT_W'(found_ff), 1'b0,
                                 RANGE_W'(t2_new), sat_now, 1'b1);
            end else begin
               rsp_in = make_rsp(RANGE_W'(base_ff), RANGE_W'(hi_ff), RANGE_W'(t2),
                                 SYMOUT_W'(found_ff), 1'b0, RANGE_W'(t2_new),
                                 sat_now, 1'b1);
            end
         end

         ST_SECOND: begin
            // total already holds the updated count here
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            rsp_in = make_rsp(lo_u, lo_u + 1'b1, RANGE_W'(unseen_ff), SYMOUT_W'(sym_ff),
                              1'b0, RANGE_W'(t2), sat_ff, 1'b1);
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         addr_ff         <= '0;
         issue_ff        <= 1'b0;
         proc_valid_ff   <= 1'b0;
         total_ff        <= '0;
         distinct_ff     <= '0;
         after_escape_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         addr_ff         <= addr_in;
         issue_ff        <= issue_in;
         proc_valid_ff   <= proc_valid_in;
         total_ff        <= total_in;
         distinct_ff     <= distinct_in;
         after_escape_ff <= after_escape_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      proc_idx_ff  <= proc_idx_in;
      op_ff        <= op_in;
      aesc_mode_ff <= aesc_mode_in;
      sym_ff       <= sym_in;
      tgt_ff       <= tgt_in;
      tgtc_ff      <= tgtc_in;
      unseen_ff    <= unseen_in;
      base_ff      <= base_in;
      hi_ff        <= hi_in;
      u_ff         <= u_in;
      run_ff       <= run_in;
      found_ff     <= found_in;
      found_hit_ff <= found_hit_in;
      cfound_ff    <= cfound_in;
      sat_ff       <= sat_in;
      rsp_ff       <= rsp_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/emd_checker.sv =====
// ----------------------------------------------------------------------------
// emd_checker
// Port-level checks on result sequencing of the escape method D model.
// ----------------------------------------------------------------------------
module emd_checker #(
   parameter int NUM_SYMBOLS = 256
) (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input emd_pkg::rsp_type rsp_payload
);

   import emd_pkg::*;

   localparam logic [SYMOUT_W-1:0] ESC_SYM = SYMOUT_W'(NUM_SYMBOLS);

   // a result follows an accepted transaction or ongoing work
   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy || start))
      else $error("result without a pending transaction");

   // a first result of two is immediately followed by the second
   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.last) |=> rsp_valid)
      else $error("second result missing");

   // hold off new transactions while the second result is pending
   a_busy_between: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.last) |-> busy)
      else $error("accepting while a result is still owed");

   // only an escape result precedes another result of the same transaction
   a_first_is_escape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.last) |-> rsp_payload.is_escape)
      else $error("non-escape result not marked last");

   a_escape_symbol: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.is_escape) |-> (rsp_payload.symbol_out == ESC_SYM))
      else $error("escape result with wrong symbol code");

endmodule

bind escape_method_d_adaptive_model_top emd_checker #(
   .NUM_SYMBOLS (NUM_SYMBOLS)
) u_emd_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload)
);
